// ===== rtl/cmmu_pkg.sv =====
// ----------------------------------------------------------------------------
// cmmu_pkg
// Shared types, constants and trig tables of the clock model update unit.
// ----------------------------------------------------------------------------
package cmmu_pkg;

   localparam int ANGLE_W  = 3;
   localparam int COORD_W  = 8;
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int SIDE_W   = 9;
   localparam logic [SIDE_W-1:0] MAX_SIDE = 9'd256;

   localparam logic signed [16:0] COS0 = 17'sd32767;
   localparam logic signed [16:0] C45  = 17'sd23170;

   // ln 2 in Q30 and the argument at or above which the probability is zero.
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [45:0] EXP_LIMIT = 46'd31 * 46'd744261118;

   // Configuration register indexes.
   localparam logic [1:0] REG_COUPLING_J = 2'd0;
   localparam logic [1:0] REG_FIELD_H    = 2'd1;
   localparam logic [1:0] REG_INV_TEMP   = 2'd2;
   localparam logic [1:0] REG_SIDE       = 2'd3;

   // Neighbor read slots.
   localparam logic [2:0] SLOT_CENTER = 3'd0;
   localparam logic [2:0] SLOT_CP     = 3'd1;
   localparam logic [2:0] SLOT_CM     = 3'd2;
   localparam logic [2:0] SLOT_RP     = 3'd3;
   localparam logic [2:0] SLOT_RM     = 3'd4;

   typedef struct packed {
      logic                 rd_en;
      logic [2:0]           slot;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic                 wr_en;
      logic [ANGLE_W-1:0]   wr_angle;
   } lat_req_type;

   function automatic logic signed [16:0] cos_q15(input logic [ANGLE_W-1:0] idx);
      logic signed [16:0] v;
      case (idx)
         3'd0: v = COS0;
         3'd1: v = C45;
         3'd2: v = 17'sd0;
         3'd3: v = -C45;
         3'd4: v = -COS0;
         3'd5: v = -C45;
         3'd6: v = 17'sd0;
         3'd7: v = C45;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] sin_q15(input logic [ANGLE_W-1:0] idx);
      logic signed [16:0] v;
      case (idx)
         3'd0: v = 17'sd0;
         3'd1: v = C45;
         3'd2: v = COS0;
         3'd3: v = C45;
         3'd4: v = 17'sd0;
         3'd5: v = -C45;
         3'd6: v = -COS0;
         3'd7: v = -C45;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/cmmu_lattice.sv =====
// ----------------------------------------------------------------------------
// cmmu_lattice
// Spin angle memory with wrapped neighbor addressing and a clearing sweep.
// ----------------------------------------------------------------------------
module cmmu_lattice (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cmmu_pkg::SIDE_W-1:0]       side,
   input  cmmu_pkg::lat_req_type             req,
   input  logic                              clear_start,
   output logic                              busy,
   output logic [cmmu_pkg::ANGLE_W-1:0]      rd_angle
);

   logic [cmmu_pkg::ANGLE_W-1:0] mem [2**cmmu_pkg::ADDR_W];
   logic [cmmu_pkg::ANGLE_W-1:0] rd_angle_ff;
   logic                         busy_ff, busy_in;
   logic [cmmu_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic [cmmu_pkg::COORD_W-1:0] rp, rm, cp, cm, rd_row, rd_col;
   logic [cmmu_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
   logic [cmmu_pkg::ANGLE_W-1:0] wr_data;
   logic                         wr_en;

   always_comb begin
      rp = ({1'b0, req.row} + 9'd1 == side) ? '0 : req.row + 8'd1;
      rm = (req.row == '0) ? 8'(side - 9'd1) : req.row - 8'd1;
      cp = ({1'b0, req.col} + 9'd1 == side) ? '0 : req.col + 8'd1;
      cm = (req.col == '0) ? 8'(side - 9'd1) : req.col - 8'd1;
      rd_row = req.row;
      rd_col = req.col;
      case (req.slot)
         cmmu_pkg::SLOT_CENTER: ;
         cmmu_pkg::SLOT_CP: rd_col = cp;
         cmmu_pkg::SLOT_CM: rd_col = cm;
         cmmu_pkg::SLOT_RP: rd_row = rp;
         cmmu_pkg::SLOT_RM: rd_row = rm;
         default: ;
      endcase
      rd_addr = {rd_row, rd_col};
      wr_en   = busy_ff | req.wr_en;
      wr_addr = busy_ff ? clr_ff : {req.row, req.col};
      wr_data = busy_ff ? '0 : req.wr_angle;
   end

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (clear_start) begin
         busy_in = 1'b1;
         clr_in  = '0;
      end else if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == '1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         rd_angle_ff <= mem[rd_addr];
      end
   end

   assign busy     = busy_ff;
   assign rd_angle = rd_angle_ff;

endmodule

// ===== rtl/cmmu_exp_unit.sv =====
// ----------------------------------------------------------------------------
// cmmu_exp_unit
// Iterative exp(-x) in Q1.16: ln2 range reduction, then a twelve term series
// with its two multipliers reused by every term; each term is divided by its
// index through a multiply by a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module cmmu_exp_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [35:0] x20,
   output logic        done,
   output logic [16:0] prob
);

   typedef enum logic [2:0] {E_IDLE, E_RED, E_MUL, E_DIV, E_FIN} state_type;

   state_type   state_ff, state_in;
   logic [34:0] rem_ff, rem_in;
   logic [4:0]  n_ff, n_in;
   logic [2:0]  bit_ff, bit_in;
   logic [30:0] t_ff, t_in;
   logic [31:0] pos_ff, pos_in, neg_ff, neg_in;
   logic [3:0]  k_ff, k_in;
   logic [29:0] q_ff, q_in;
   logic [16:0] prob_ff, prob_in;
   logic        done_ff, done_in;

   logic [45:0] xq;
   logic [34:0] ln2_sh;
   logic [59:0] prod;
   logic [34:0] recip;
   logic [64:0] qprod;
   logic [30:0] quo;
   logic [31:0] e;
   logic [5:0]  s;
   logic [47:0] rsum, rshift;

   // ceil(2^34 / k). The series terms stay below 2^30, so the product shifted
   // down by 34 is the exact floor of the quotient.
   function automatic logic [34:0] recip_of(input logic [3:0] k);
      logic [34:0] v;
      case (k)
         4'd1:    v = 35'd17179869184;
         4'd2:    v = 35'd8589934592;
         4'd3:    v = 35'd5726623062;
         4'd4:    v = 35'd4294967296;
         4'd5:    v = 35'd3435973837;
         4'd6:    v = 35'd2863311531;
         4'd7:    v = 35'd2454267027;
         4'd8:    v = 35'd2147483648;
         4'd9:    v = 35'd1908874354;
         4'd10:   v = 35'd1717986919;
         4'd11:   v = 35'd1561806290;
         4'd12:   v = 35'd1431655766;
         default: v = 35'd0;
      endcase
      return v;
   endfunction

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      n_in     = n_ff;
      bit_in   = bit_ff;
      t_in     = t_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      q_in     = q_ff;
      prob_in  = prob_ff;
      done_in  = 1'b0;

      xq     = {x20, 10'd0};
      ln2_sh = {5'd0, cmmu_pkg::LN2_Q30} << bit_ff;
      prod   = 60'(t_ff * rem_ff[29:0]);
      recip  = recip_of(k_ff);
      qprod  = 65'(q_ff * recip);
      quo    = qprod[64:34];
      e      = pos_ff - neg_ff;
      s      = {1'b0, n_ff} + 6'd14;
      rsum   = {16'd0, e} + (48'd1 << (s - 6'd1));
      rshift = rsum >> s;

      case (state_ff)
         E_IDLE: begin
            if (start) begin
               if (xq >= cmmu_pkg::EXP_LIMIT) begin
                  prob_in = '0;
                  done_in = 1'b1;
               end else begin
                  rem_in   = xq[34:0];
                  n_in     = '0;
                  bit_in   = 3'd4;
                  state_in = E_RED;
               end
            end
         end
         E_RED: begin
            if (rem_ff >= ln2_sh) begin
               rem_in       = rem_ff - ln2_sh;
               n_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               t_in     = 31'd1 << 30;
               pos_in   = 32'd1 << 30;
               neg_in   = '0;
               k_in     = 4'd1;
               state_in = E_MUL;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         E_MUL: begin
            q_in     = prod[59:30];
            state_in = E_DIV;
         end
         E_DIV: begin
            t_in = quo;
            if (k_ff[0]) begin
               neg_in = neg_ff + {1'b0, quo};
            end else begin
               pos_in = pos_ff + {1'b0, quo};
            end
            if (k_ff == 4'd12) begin
               state_in = E_FIN;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = E_MUL;
            end
         end
         E_FIN: begin
            prob_in  = rshift[16:0];
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      n_ff    <= n_in;
      bit_ff  <= bit_in;
      t_ff    <= t_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
      k_ff    <= k_in;
      q_ff    <= q_in;
      prob_ff <= prob_in;
   end

   assign done = done_ff;
   assign prob = prob_ff;

endmodule

// ===== rtl/clock_model_metropolis_update_unit.sv =====
// ----------------------------------------------------------------------------
// clock_model_metropolis_update_unit
// Metropolis update of a discrete-angle spin lattice with running totals.
// ----------------------------------------------------------------------------
// Update: 5 lattice reads through the lattice's single request port, then dE in
// the DIFF, MUL, SUM and XMUL states. A lowering move is accepted there; otherwise
// the exp unit runs (12 terms, a multiply and a reciprocal multiply each), or skips
// the series when the probability is zero. An off-lattice word goes straight to its
// result. Init word: INIT_MUL, INIT_SHIFT and INIT_TOT, then the result and a clearing
// sweep of the lattice; reset starts the same sweep. Next word is taken in IDLE.
module clock_model_metropolis_update_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // row, col, angle_step, uniform, zero pad
   input  logic [0:0]   req_tuser,   // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // accepted, bad_site, site_angle,
                                     // total_energy, mag_x, mag_y, zero pad
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_DIFF, S_MUL, S_SUM, S_XMUL, S_EXP_GO, S_EXP,
      S_INIT_MUL, S_INIT_SHIFT, S_INIT_TOT, S_DONE
   } state_type;

   // Configuration.
   logic signed [15:0] coupling_ff, field_ff;
   logic [15:0]        inv_temp_ff;
   logic [8:0]         side_reg_ff;
   logic [8:0]         side;

   state_type          state_ff, state_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [7:0]         row_ff, row_in, col_ff, col_in;
   logic [2:0]         step_ff, step_in;
   logic [15:0]        uni_ff, uni_in;
   logic               init_ff, init_in, bad_ff, bad_in, acc_ff, acc_in;
   logic [2:0]         ang_ff [5];
   logic [2:0]         ang_in [5];
   logic signed [19:0] ds_ff, ds_in;
   logic signed [16:0] dcx_ff, dcx_in, dsy_ff, dsy_in;
   logic signed [35:0] pj_ff, pj_in;
   logic signed [32:0] ph_ff, ph_in;
   logic signed [20:0] de_ff, de_in;
   logic [35:0]        x20_ff, x20_in;
   logic signed [33:0] iprod_ff, iprod_in;
   logic [16:0]        nsq_ff, nsq_in;
   logic signed [18:0] per_ff, per_in;
   logic [39:0]        ie_ff, ie_in, energy_ff, energy_in;
   logic [32:0]        imx_ff, imx_in, magx_ff, magx_in, magy_ff, magy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [111:0]       rsp_data_ff, rsp_data_in;

   cmmu_pkg::lat_req_type lat_req;
   logic                  clear_start, lat_busy;
   logic [2:0]            rd_angle;
   logic                  exp_start, exp_done;
   logic [16:0]           exp_prob;

   logic [2:0]            prop, cur, dn, dd, out_angle;
   logic signed [17:0]    sum_new, sum_old;
   logic signed [36:0]    vsum;
   logic signed [17:0]    jh2;
   logic                  slot_free;

   assign side = (side_reg_ff > cmmu_pkg::MAX_SIDE) ? cmmu_pkg::MAX_SIDE : side_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= 16'sd4096;
         field_ff    <= 16'sd0;
         inv_temp_ff <= 16'd256;
         side_reg_ff <= 9'd256;
      end else if (csr_we) begin
         case (csr_addr)
            cmmu_pkg::REG_COUPLING_J: coupling_ff <= csr_wdata;
            cmmu_pkg::REG_FIELD_H:    field_ff    <= csr_wdata;
            cmmu_pkg::REG_INV_TEMP:   inv_temp_ff <= csr_wdata;
            cmmu_pkg::REG_SIDE:       side_reg_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   cmmu_lattice u_lattice (
      .clock       (clock),
      .reset       (reset),
      .side        (side),
      .req         (lat_req),
      .clear_start (clear_start),
      .busy        (lat_busy),
      .rd_angle    (rd_angle)
   );

   cmmu_exp_unit u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .x20   (x20_ff),
      .done  (exp_done),
      .prob  (exp_prob)
   );

   assign cur  = ang_ff[0];
   assign prop = ang_ff[0] + step_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      uni_in       = uni_ff;
      init_in      = init_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      ang_in       = ang_ff;
      ds_in        = ds_ff;
      dcx_in       = dcx_ff;
      dsy_in       = dsy_ff;
      pj_in        = pj_ff;
      ph_in        = ph_ff;
      de_in        = de_ff;
      x20_in       = x20_ff;
      iprod_in     = iprod_ff;
      nsq_in       = nsq_ff;
      per_in       = per_ff;
      ie_in        = ie_ff;
      imx_in       = imx_ff;
      energy_in    = energy_ff;
      magx_in      = magx_ff;
      magy_in      = magy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      clear_start  = 1'b0;
      exp_start    = 1'b0;
      out_angle    = '0;

      lat_req          = '0;
      lat_req.row      = row_ff;
      lat_req.col      = col_ff;
      lat_req.slot     = cnt_ff;
      lat_req.wr_angle = prop;

      sum_new = '0;
      sum_old = '0;
      for (int i = 1; i < 5; i++) begin
         dn = (prop > ang_ff[i]) ? prop - ang_ff[i] : ang_ff[i] - prop;
         dd = (cur > ang_ff[i]) ? cur - ang_ff[i] : ang_ff[i] - cur;
         sum_new = sum_new + 18'(cmmu_pkg::cos_q15(dn));
         sum_old = sum_old + 18'(cmmu_pkg::cos_q15(dd));
      end
      vsum = -37'(pj_ff) - 37'(ph_ff) + 37'sd16384;
      jh2  = 18'(coupling_ff) * 18'sd2 + 18'(field_ff);

      slot_free = !rsp_valid_ff || rsp_tready;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            if (!lat_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               row_in  = req_tdata[7:0];
               col_in  = req_tdata[15:8];
               step_in = req_tdata[18:16];
               uni_in  = req_tdata[34:19];
               init_in = req_tuser[0];
               acc_in  = 1'b0;
               bad_in  = 1'b0;
               cnt_in  = '0;
               if (req_tuser[0]) begin
                  state_in = S_INIT_MUL;
               end else if ({1'b0, req_tdata[7:0]} >= side ||
                            {1'b0, req_tdata[15:8]} >= side) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // Read data arrives in the cycle after its address.
            lat_req.rd_en = (cnt_ff != 3'd5);
            if (cnt_ff != '0) begin
               ang_in[cnt_ff - 3'd1] = rd_angle;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            ds_in    = 20'(sum_new) - 20'(sum_old);
            dcx_in   = cmmu_pkg::cos_q15(prop) - cmmu_pkg::cos_q15(cur);
            dsy_in   = cmmu_pkg::sin_q15(prop) - cmmu_pkg::sin_q15(cur);
            state_in = S_MUL;
         end
         S_MUL: begin
            pj_in    = 36'(coupling_ff) * 36'(ds_ff);
            ph_in    = 33'(field_ff) * 33'(dcx_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            // Round half up to signed Q8.12.
            de_in    = 21'(vsum >>> 15);
            state_in = S_XMUL;
         end
         S_XMUL: begin
            if (de_ff < 0) begin
               acc_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               x20_in   = 36'(de_ff[19:0]) * 36'(inv_temp_ff);
               state_in = S_EXP_GO;
            end
         end
         S_EXP_GO: begin
            exp_start = 1'b1;
            state_in  = S_EXP;
         end
         S_EXP: begin
            if (exp_done) begin
               acc_in   = {1'b0, uni_ff} <= exp_prob;
               state_in = S_DONE;
            end
         end
         S_INIT_MUL: begin
            iprod_in = -(34'(jh2) * 34'(cmmu_pkg::COS0));
            nsq_in   = 17'(side * side);
            state_in = S_INIT_SHIFT;
         end
         S_INIT_SHIFT: begin
            per_in   = 19'((iprod_ff + 34'sd16384) >>> 15);
            state_in = S_INIT_TOT;
         end
         S_INIT_TOT: begin
            ie_in    = 40'(37'(per_ff) * 37'($signed({1'b0, nsq_ff})));
            imx_in   = 33'(nsq_ff * 17'(cmmu_pkg::COS0));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               if (init_ff) begin
                  energy_in   = ie_ff;
                  magx_in     = imx_ff;
                  magy_in     = '0;
                  clear_start = 1'b1;
                  state_in    = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
                  if (!bad_ff) begin
                     out_angle = cur;
                     if (acc_ff) begin
                        out_angle     = prop;
                        lat_req.wr_en = 1'b1;
                        energy_in     = energy_ff + 40'(de_ff);
                        magx_in       = magx_ff + 33'(dcx_ff);
                        magy_in       = magy_ff + 33'(dsy_ff);
                     end
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, magy_in, magx_in, energy_in, out_angle, bad_ff,
                               acc_ff & ~bad_ff & ~init_ff};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         magx_ff      <= '0;
         magy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         magx_ff      <= magx_in;
         magy_ff      <= magy_in;
      end
      cnt_ff      <= cnt_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      step_ff     <= step_in;
      uni_ff      <= uni_in;
      init_ff     <= init_in;
      bad_ff      <= bad_in;
      acc_ff      <= acc_in;
      ang_ff      <= ang_in;
      ds_ff       <= ds_in;
      dcx_ff      <= dcx_in;
      dsy_ff      <= dsy_in;
      pj_ff       <= pj_in;
      ph_ff       <= ph_in;
      de_ff       <= de_in;
      x20_ff      <= x20_in;
      iprod_ff    <= iprod_in;
      nsq_ff      <= nsq_in;
      per_ff      <= per_in;
      ie_ff       <= ie_in;
      imx_ff      <= imx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
